// File: sv/neighbor_record_hex_parser_defines.svh
// ----------------------------------------------------------------------------
// neighbor record hex parser assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_RECORD_HEX_PARSER_DEFINES_SVH
`define NEIGHBOR_RECORD_HEX_PARSER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define NRHP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NRHP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/nrhp_pkg.sv
// ----------------------------------------------------------------------------
// nrhp_pkg
// shared types, constants and the hex digit decoder of the record parser
// ----------------------------------------------------------------------------
package nrhp_pkg;

	localparam int RECORD_BYTES_DEF = 48;
	localparam int TABLE_SLOTS_DEF  = 8;
	localparam int QUEUE_DEPTH      = 2;
	localparam int MAX_BEATS        = 8;

	localparam logic [7:0] START_CHAR      = 8'h46;
	localparam logic [7:0] ADDR_LO0        = 8'd5;
	localparam logic [7:0] ADDR_HI0        = 8'd12;
	localparam logic [7:0] ADDR_LO1        = 8'd14;
	localparam logic [7:0] ADDR_HI1        = 8'd21;
	localparam logic [7:0] STRENGTH_HI_POS = 8'd46;
	localparam logic [7:0] STRENGTH_LO_POS = 8'd47;

	typedef struct packed {
		logic       bad;
		logic [3:0] nib;
	} hex_t;

	// one queued unit of output work: an optional record entry, then cleared
	// slots, then an optional overflow marker
	typedef struct packed {
		logic        rec;
		logic [2:0]  rec_idx;
		logic [63:0] addr;
		logic [7:0]  strength;
		logic        bad;
		logic        rec_ovf;
		logic [3:0]  nclr;
		logic [2:0]  clr_start;
		logic        end_ovf;
		logic        marker;
	} job_t;

	typedef enum logic [1:0] {
		BK_START,
		BK_REC,
		BK_CLR,
		BK_MARK
	} back_phase_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t       r;
		logic [7:0] t;
		r = '0;
		t = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
			r.nib = t[3:0];
		end else if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h37;
			r.nib = t[3:0];
		end else begin
			r.bad = 1'b1;
		end
		return r;
	endfunction

endpackage

// File: sv/nrhp_front.sv
// ----------------------------------------------------------------------------
// nrhp_front
// byte intake: alignment, record position tracking, hex decode, job build
// ----------------------------------------------------------------------------
module nrhp_front #(
	parameter int RECORD_BYTES = nrhp_pkg::RECORD_BYTES_DEF,
	parameter int TABLE_SLOTS  = nrhp_pkg::TABLE_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              end_of_response,
	output logic              push,
	output nrhp_pkg::job_t    push_job
);
	import nrhp_pkg::*;

	localparam int POS_W = $clog2(RECORD_BYTES);
	localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(RECORD_BYTES - 1);
	localparam logic [CNT_W-1:0] SLOTS_C  = CNT_W'(TABLE_SLOTS);

	logic             aligned_q, aligned_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic             bad_q, bad_n;
	logic             ovf_q, ovf_n;
	logic [63:0]      acc_q, acc_n;
	logic [3:0]       hn_q, hn_n;
	logic [7:0]       str_q, str_n;

	hex_t             dec;
	logic             aln;
	logic [7:0]       p8;
	logic             in_addr;
	logic             at_hi;
	logic             at_lo;
	logic [CNT_W-1:0] start;
	logic [4:0]       avail;
	logic [3:0]       cap;
	job_t             job;

	always_comb begin
		dec     = hex_decode(data_byte);
		aln     = aligned_q || (data_byte == START_CHAR);
		p8      = 8'(pos_q);
		in_addr = (p8 >= ADDR_LO0 && p8 <= ADDR_HI0) || (p8 >= ADDR_LO1 && p8 <= ADDR_HI1);
		at_hi   = (p8 == STRENGTH_HI_POS);
		at_lo   = (p8 == STRENGTH_LO_POS);

		aligned_n = aligned_q;
		pos_n     = pos_q;
		count_n   = count_q;
		bad_n     = bad_q;
		ovf_n     = ovf_q;
		acc_n     = acc_q;
		hn_n      = hn_q;
		str_n     = str_q;
		start     = '0;
		avail     = '0;
		cap       = '0;
		job       = '0;
		push      = 1'b0;

		if (accept) begin
			if (aln) begin
				aligned_n = 1'b1;
				if (in_addr) begin
					acc_n = {acc_q[59:0], dec.nib};
				end
				if (at_hi) begin
					hn_n = dec.nib;
				end
				if (at_lo) begin
					str_n = {hn_q, dec.nib};
				end
				bad_n = bad_q | (dec.bad & (in_addr | at_hi | at_lo));
				if (pos_q == LAST_POS) begin
					if (count_q < SLOTS_C) begin
						job.rec      = 1'b1;
						job.rec_idx  = 3'(count_q);
						job.addr     = acc_n;
						job.strength = str_n;
						job.bad      = bad_n;
						job.rec_ovf  = ovf_q;
						count_n      = count_q + 1'b1;
					end else begin
						ovf_n = 1'b1;
					end
					pos_n = '0;
					bad_n = 1'b0;
				end else begin
					pos_n = pos_q + 1'b1;
				end
			end
			if (end_of_response) begin
				// remaining slots, capped so a run never exceeds eight beats
				start         = count_n;
				avail         = 5'(TABLE_SLOTS) - 5'(start);
				cap           = job.rec ? 4'(MAX_BEATS - 1) : 4'(MAX_BEATS);
				job.nclr      = (avail > 5'(cap)) ? cap : avail[3:0];
				job.clr_start = 3'(start);
				job.end_ovf   = ovf_n;
				job.marker    = (start == SLOTS_C) && ovf_n;
				aligned_n     = 1'b0;
				pos_n         = '0;
				count_n       = '0;
				bad_n         = 1'b0;
				ovf_n         = 1'b0;
			end
			push = job.rec | (job.nclr != 4'd0) | job.marker;
		end
	end

	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aligned_q <= 1'b0;
			pos_q     <= '0;
			count_q   <= '0;
			bad_q     <= 1'b0;
			ovf_q     <= 1'b0;
		end else begin
			aligned_q <= aligned_n;
			pos_q     <= pos_n;
			count_q   <= count_n;
			bad_q     <= bad_n;
			ovf_q     <= ovf_n;
		end
	end

	// fully rewritten within every record before use
	always_ff @(posedge clk) begin
		acc_q <= acc_n;
		hn_q  <= hn_n;
		str_q <= str_n;
	end

endmodule

// File: sv/nrhp_queue.sv
// ----------------------------------------------------------------------------
// nrhp_queue
// short job queue between the byte intake and the beat expander
// ----------------------------------------------------------------------------
`include "neighbor_record_hex_parser_defines.svh"

module nrhp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nrhp_pkg::job_t push_job,
	input  logic           pop,
	output nrhp_pkg::job_t head,
	output logic           empty,
	output logic           full
);
	import nrhp_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0]    DEPTH_C  = CW'(QUEUE_DEPTH);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == DEPTH_C);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`NRHP_ASSERT_NOW(a_no_push_full, push, count_q < DEPTH_C, "job pushed into full queue")
	`NRHP_ASSERT_NOW(a_no_pop_empty, pop, count_q != '0, "job popped from empty queue")
	`NRHP_ASSERT_NOW(a_count_range, 1'b1, count_q <= DEPTH_C, "queue count out of range")

endmodule

// File: sv/nrhp_back.sv
// ----------------------------------------------------------------------------
// nrhp_back
// expands queued jobs into result beats behind an output register
// ----------------------------------------------------------------------------
`include "neighbor_record_hex_parser_defines.svh"

module nrhp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  nrhp_pkg::job_t head,
	input  logic           empty,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [2:0]     node_index,
	output logic [63:0]    node_address,
	output logic [7:0]     signal_strength,
	output logic           filled,
	output logic           bad_digit,
	output logic           table_overflow,
	output logic           last_of_run
);
	import nrhp_pkg::*;

	back_phase_t phase_q, phase_n, cur_ph;
	logic [2:0]  k_q, k_n;
	logic        load;
	logic        beat_fire;
	logic        clr_done;

	logic [2:0]  b_idx;
	logic [63:0] b_addr;
	logic [7:0]  b_str;
	logic        b_fill;
	logic        b_bad;
	logic        b_ovf;
	logic        b_last;

	logic        out_valid_q;
	logic [2:0]  idx_q;
	logic [63:0] addr_q;
	logic [7:0]  str_q;
	logic        fill_q;
	logic        bad_q;
	logic        ovf_q;
	logic        last_q;

	assign load      = !out_valid_q || !out_stall;
	assign beat_fire = !empty && load;
	assign clr_done  = (({1'b0, k_q} + 4'd1) == head.nclr);
	assign pop       = beat_fire && b_last;

	// resolve the entry phase of a fresh job
	always_comb begin
		priority if (phase_q != BK_START) begin
			cur_ph = phase_q;
		end else if (head.rec) begin
			cur_ph = BK_REC;
		end else if (head.nclr != 4'd0) begin
			cur_ph = BK_CLR;
		end else begin
			cur_ph = BK_MARK;
		end
	end

	// next state
	always_comb begin
		phase_n = phase_q;
		k_n     = k_q;
		if (beat_fire) begin
			unique case (cur_ph)
				BK_REC: begin
					k_n = '0;
					if (b_last) begin
						phase_n = BK_START;
					end else if (head.nclr != 4'd0) begin
						phase_n = BK_CLR;
					end else begin
						phase_n = BK_MARK;
					end
				end
				BK_CLR: begin
					if (clr_done) begin
						k_n     = '0;
						phase_n = head.marker ? BK_MARK : BK_START;
					end else begin
						k_n     = k_q + 1'b1;
						phase_n = BK_CLR;
					end
				end
				BK_MARK: begin
					k_n     = '0;
					phase_n = BK_START;
				end
				BK_START: begin
					phase_n = BK_START;
				end
			endcase
		end
	end

	// beat contents
	always_comb begin
		b_idx  = '0;
		b_addr = '0;
		b_str  = '0;
		b_fill = 1'b0;
		b_bad  = 1'b0;
		b_ovf  = 1'b0;
		b_last = 1'b0;
		unique case (cur_ph)
			BK_REC: begin
				b_idx  = head.rec_idx;
				b_addr = head.addr;
				b_str  = head.strength;
				b_fill = 1'b1;
				b_bad  = head.bad;
				b_ovf  = head.rec_ovf;
				b_last = (head.nclr == 4'd0) && !head.marker;
			end
			BK_CLR: begin
				b_idx  = head.clr_start + k_q;
				b_ovf  = head.end_ovf;
				b_last = clr_done && !head.marker;
			end
			BK_MARK: begin
				b_ovf  = 1'b1;
				b_last = 1'b1;
			end
			BK_START: begin
				b_last = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= BK_START;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_n;
			k_q     <= k_n;
			if (load) begin
				out_valid_q <= !empty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat_fire) begin
			idx_q  <= b_idx;
			addr_q <= b_addr;
			str_q  <= b_str;
			fill_q <= b_fill;
			bad_q  <= b_bad;
			ovf_q  <= b_ovf;
			last_q <= b_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign node_index      = idx_q;
	assign node_address    = addr_q;
	assign signal_strength = str_q;
	assign filled          = fill_q;
	assign bad_digit       = bad_q;
	assign table_overflow  = ovf_q;
	assign last_of_run     = last_q;

	`NRHP_ASSERT_NOW(a_busy_has_job, phase_q != BK_START, !empty, "mid-job with empty queue")
	`NRHP_ASSERT_NEXT(a_run_end_idle, beat_fire && b_last, phase_q == BK_START, "run end not idle")
	`NRHP_ASSERT_NOW(a_clr_in_range, phase_q == BK_CLR, ({1'b0, k_q} < head.nclr), "clear index past count")

endmodule

// File: sv/neighbor_record_hex_parser.sv
// ----------------------------------------------------------------------------
// neighbor_record_hex_parser
// turns the byte stream of a neighbor-discovery response into table entries
// ----------------------------------------------------------------------------
// The block takes one response byte per cycle on the input channel and never
// stalls it while the job queue has room. Bytes are dropped until the first
// 'F'; from there the stream is cut into RECORD_BYTES-byte records. Each
// complete record yields one filled entry (64-bit address from the hex pairs
// at offsets 5-12 and 14-21, strength from the pair at offset 46). The byte
// flagged end_of_response additionally yields cleared entries for the unused
// slots, at most eight beats in total, or a single overflow marker when the
// table was full and records were dropped. Bytes that produce no entry are
// taken without creating a job. Bytes that do produce entries are turned
// into a job and put on a two-entry queue; the output side expands each job
// into beats at one beat per cycle through its output register while the
// output is not stalled, so an end byte occupies the output for up to eight
// beats. The input stalls only when the queue is full, that is while one job
// is still being expanded and a second one is waiting, for example a second
// end byte arriving before the first one's beats are out, or any two jobs
// held up behind a stalled output. A partial trailing record is dropped; an
// invalid hex digit is decoded as zero and reported in bad_digit on that
// record's entry.
// ----------------------------------------------------------------------------
module neighbor_record_hex_parser #(
	parameter int RECORD_BYTES = nrhp_pkg::RECORD_BYTES_DEF,
	parameter int TABLE_SLOTS  = nrhp_pkg::TABLE_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_response,
	// entry output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  node_index,
	output logic [63:0] node_address,
	output logic [7:0]  signal_strength,
	output logic        filled,
	output logic        bad_digit,
	output logic        table_overflow,
	output logic        last_of_run
);
	import nrhp_pkg::*;

	logic accept;
	logic push;
	job_t push_job;
	logic pop;
	job_t head;
	logic empty;
	logic full;

	// a byte is taken whenever the queue can absorb the job it might create
	assign in_stall = full;
	assign accept   = in_valid && !in_stall;

	// front: alignment, position count and hex decode, one byte per cycle unless the queue is full
	nrhp_front #(
		.RECORD_BYTES (RECORD_BYTES),
		.TABLE_SLOTS  (TABLE_SLOTS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.data_byte       (data_byte),
		.end_of_response (end_of_response),
		.push            (push),
		.push_job        (push_job)
	);

	// decoupling queue, holds jobs while the output side is busy or stalled
	nrhp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	// back: one entry beat per cycle unless the output stalls, registered outputs
	nrhp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.empty           (empty),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.node_index      (node_index),
		.node_address    (node_address),
		.signal_strength (signal_strength),
		.filled          (filled),
		.bad_digit       (bad_digit),
		.table_overflow  (table_overflow),
		.last_of_run     (last_of_run)
	);

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// neighbor record hex parser testbench
// drives response byte streams, predicts every table entry, checks each beat
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import nrhp_pkg::*;

	localparam int REC_LEN      = RECORD_BYTES_DEF;
	localparam int SLOTS        = TABLE_SLOTS_DEF;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;

	// one table entry as seen on the output channel
	typedef struct packed {
		logic [2:0]  idx;
		logic [63:0] addr;
		logic [7:0]  rssi;
		logic        filled;
		logic        bad;
		logic        ovf;
		logic        last;
	} node_entry_t;

	typedef enum {
		RK_BYTE,
		RK_RECORD,
		RK_PARTIAL
	} row_kind_t;

	// one row of the directed table; typed rows carry the expected beats of
	// their final byte as a run of exp_n entries counting up from exp.idx
	typedef struct {
		row_kind_t   kind;
		logic [7:0]  b;
		logic        eor;
		logic [63:0] addr;
		logic [7:0]  rssi;
		int          bad_at;
		int          len;
		logic        typed;
		int          exp_n;
		node_entry_t exp;
	} stim_row_t;

	logic        clk             = 1'b0;
	logic        arst_n          = 1'b0;
	logic        in_valid        = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte       = 8'h00;
	logic        end_of_response = 1'b0;
	logic        out_valid;
	logic        out_stall       = 1'b0;
	logic [2:0]  node_index;
	logic [63:0] node_address;
	logic [7:0]  signal_strength;
	logic        filled;
	logic        bad_digit;
	logic        table_overflow;
	logic        last_of_run;

	// expected beats, oldest first
	node_entry_t pending_entries[$];

	int fail_count      = 0;
	int entries_checked = 0;
	int bytes_sent      = 0;
	int responses_sent  = 0;
	int cycle_count     = 0;
	int send_idle_pct   = 0;
	int recv_idle_pct   = 0;
	int hold_request    = 0;
	int hold_left       = 0;

	// shadow of the parser state
	logic        trk_aligned = 1'b0;
	int          trk_pos     = 0;
	int          trk_count   = 0;
	logic [63:0] trk_addr    = '0;
	logic [3:0]  trk_hi      = '0;
	logic [7:0]  trk_rssi    = '0;
	logic        trk_bad     = 1'b0;
	logic        trk_ovf     = 1'b0;

	stim_row_t directed_rows[$];

	neighbor_record_hex_parser u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.end_of_response (end_of_response),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.node_index      (node_index),
		.node_address    (node_address),
		.signal_strength (signal_strength),
		.filled          (filled),
		.bad_digit       (bad_digit),
		.table_overflow  (table_overflow),
		.last_of_run     (last_of_run)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// uppercase hex only; anything else decodes as zero and marks bad
	function automatic logic [3:0] hex_nibble(input logic [7:0] c, ref logic bad);
		if (c >= 8'h30 && c <= 8'h39)
			return c[3:0];
		if (c >= 8'h41 && c <= 8'h46)
			return c[3:0] + 4'd9;
		bad = 1'b1;
		return 4'd0;
	endfunction

	function automatic node_entry_t make_entry(input logic [2:0] idx, input logic [63:0] addr,
			input logic [7:0] rssi, input logic fill, input logic bad, input logic ovf);
		node_entry_t e;
		e.idx    = idx;
		e.addr   = addr;
		e.rssi   = rssi;
		e.filled = fill;
		e.bad    = bad;
		e.ovf    = ovf;
		e.last   = 1'b0;
		return e;
	endfunction

	// per-record fields; the overflow flag lives on for the whole response
	function automatic void clear_record_track();
		trk_pos  = 0;
		trk_addr = '0;
		trk_hi   = '0;
		trk_rssi = '0;
		trk_bad  = 1'b0;
	endfunction

	function automatic void reset_track();
		trk_aligned = 1'b0;
		trk_count   = 0;
		trk_ovf     = 1'b0;
		clear_record_track();
	endfunction

	// advance the shadow state by one byte and collect the beats it causes
	function automatic void predict_entries(input logic [7:0] c, input logic e,
			ref node_entry_t got[$]);
		logic       bad;
		logic [3:0] lo;
		int         pos;
		int         s;
		bad = 1'b0;
		got.delete();
		if (!trk_aligned && c == START_CHAR) begin
			trk_aligned = 1'b1;
			clear_record_track();
		end
		if (trk_aligned) begin
			pos = trk_pos;
			if ((pos >= ADDR_LO0 && pos <= ADDR_HI0) || (pos >= ADDR_LO1 && pos <= ADDR_HI1)) begin
				trk_addr = {trk_addr[59:0], hex_nibble(c, bad)};
			end else if (pos == STRENGTH_HI_POS) begin
				trk_hi = hex_nibble(c, bad);
			end else if (pos == STRENGTH_LO_POS) begin
				lo = hex_nibble(c, bad);
				trk_rssi = {trk_hi, lo};
			end
			if (bad)
				trk_bad = 1'b1;
			if (pos + 1 >= REC_LEN) begin
				if (trk_count < SLOTS) begin
					got.push_back(make_entry(3'(trk_count), trk_addr, trk_rssi, 1'b1,
						trk_bad, trk_ovf));
					trk_count = (trk_count + 1) & 15;
				end else begin
					trk_ovf = 1'b1;
				end
				clear_record_track();
			end else begin
				trk_pos = (pos + 1) & 255;
			end
		end
		if (e) begin
			for (s = trk_count; s < SLOTS && got.size() < MAX_BEATS; s++)
				got.push_back(make_entry(3'(s), '0, '0, 1'b0, 1'b0, trk_ovf));
			// full table with dropped records: a lone marker beat
			if (trk_count >= SLOTS && trk_ovf && got.size() < MAX_BEATS)
				got.push_back(make_entry(3'd0, '0, '0, 1'b0, 1'b0, 1'b1));
			reset_track();
		end
		if (got.size() > 0)
			got[got.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// output side: compare each accepted beat, then pick the next stall
	// ------------------------------------------------------------------------

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] seen);
		if (want !== seen) begin
			$error("%s expected %0h got %0h", name, want, seen);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : rx_side
		node_entry_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_entries.size() == 0) begin
				$error("unexpected beat: node_index %0d node_address %0h", node_index,
					node_address);
				fail_count++;
			end else begin
				want = pending_entries.pop_front();
				check_field("node_index", 64'(want.idx), 64'(node_index));
				check_field("node_address", want.addr, node_address);
				check_field("signal_strength", 64'(want.rssi), 64'(signal_strength));
				check_field("filled", 64'(want.filled), 64'(filled));
				check_field("bad_digit", 64'(want.bad), 64'(bad_digit));
				check_field("table_overflow", 64'(want.ovf), 64'(table_overflow));
				check_field("last_of_run", 64'(want.last), 64'(last_of_run));
				entries_checked++;
			end
		end
		// a long hold-off, counted here, takes priority over random stalls
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_request > 0) begin
			out_stall    <= 1'b1;
			hold_left    <= hold_request - 1;
			hold_request = 0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 10) ? 8'h30 + n : 8'h37 + n;
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		logic       bad;
		bad = 1'b0;
		c   = '0;
		while (!bad) begin
			c = 8'($urandom_range(0, 255));
			void'(hex_nibble(c, bad));
		end
		return c;
	endfunction

	function automatic logic [7:0] random_non_start();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (c == START_CHAR)
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	// one full record: the given first byte, address digits at their two windows,
	// strength pair at the tail, random filler elsewhere; bad_at below zero means clean
	function automatic void append_record(ref logic [7:0] q[$], input logic [7:0] first,
			input logic [63:0] addr, input logic [7:0] rssi, input int bad_at);
		int         p;
		logic [7:0] c;
		for (p = 0; p < REC_LEN; p++) begin
			if (p == 0)
				c = first;
			else if (p >= ADDR_LO0 && p <= ADDR_HI0)
				c = hex_char(addr[63 - 4 * (p - ADDR_LO0) -: 4]);
			else if (p >= ADDR_LO1 && p <= ADDR_HI1)
				c = hex_char(addr[31 - 4 * (p - ADDR_LO1) -: 4]);
			else if (p == STRENGTH_HI_POS)
				c = hex_char(rssi[7:4]);
			else if (p == STRENGTH_LO_POS)
				c = hex_char(rssi[3:0]);
			else
				c = 8'($urandom_range(0, 255));
			if (p == bad_at)
				c = non_hex_char();
			q.push_back(c);
		end
	endfunction

	// offer one byte, hold it until taken, then book its expected entries
	task automatic send_byte(input logic [7:0] b, input logic e, input logic typed,
			input int typed_n, input node_entry_t typed_base);
		node_entry_t got[$];
		node_entry_t t;
		int          k;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		data_byte       <= b;
		end_of_response <= e;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_entries(b, e, got);
		if (typed) begin
			for (k = 0; k < typed_n; k++) begin
				t      = typed_base;
				t.idx  = typed_base.idx + 3'(k);
				t.last = (k == typed_n - 1);
				pending_entries.push_back(t);
			end
		end else begin
			foreach (got[i])
				pending_entries.push_back(got[i]);
		end
		bytes_sent++;
		if (e)
			responses_sent++;
	endtask

	// the typed expectation, if any, belongs to the final byte
	task automatic send_bytes(input logic [7:0] q[$], input logic eor_last, input logic typed,
			input int typed_n, input node_entry_t typed_base);
		int last_i;
		last_i = q.size() - 1;
		foreach (q[i]) begin
			if (i == last_i)
				send_byte(q[i], eor_last, typed, typed_n, typed_base);
			else
				send_byte(q[i], 1'b0, 1'b0, 0, '0);
		end
	endtask

	// sender pause: nothing offered until every booked beat has arrived
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_entries.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// short responses with random content: some noise, some single records,
	// some broken tails
	task automatic random_response();
		logic [7:0] q[$];
		int         kind;
		int         nrec;
		int         r;
		int         bad_at;
		int         pick;
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			repeat ($urandom_range(1, 12)) q.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 2)) q.push_back(random_non_start());
			nrec = $urandom_range(0, 1);
			for (r = 0; r < nrec; r++) begin
				bad_at = -1;
				if ($urandom_range(0, 5) == 0) begin
					pick = $urandom_range(0, 17);
					if (pick < 8)
						bad_at = ADDR_LO0 + pick;
					else if (pick < 16)
						bad_at = ADDR_LO1 + pick - 8;
					else if (pick == 16)
						bad_at = STRENGTH_HI_POS;
					else
						bad_at = STRENGTH_LO_POS;
				end
				append_record(q, (r == 0) ? START_CHAR : 8'($urandom_range(0, 255)),
					{$urandom, $urandom}, 8'($urandom_range(0, 255)), bad_at);
			end
			// partial trailing record
			if ($urandom_range(0, 2) == 0) begin
				if (nrec == 0)
					q.push_back(START_CHAR);
				repeat ($urandom_range(1, REC_LEN - 1)) q.push_back(8'($urandom_range(0, 255)));
			end
			if (q.size() == 0)
				q.push_back(random_non_start());
		end
		send_bytes(q, 1'b1, 1'b0, 0, '0);
	endtask

	function automatic stim_row_t mk_row(input row_kind_t kind, input logic [7:0] b,
			input logic eor, input logic [63:0] addr, input logic [7:0] rssi, input int bad_at,
			input int len, input logic typed, input int exp_n, input node_entry_t exp);
		stim_row_t r;
		r.kind   = kind;
		r.b      = b;
		r.eor    = eor;
		r.addr   = addr;
		r.rssi   = rssi;
		r.bad_at = bad_at;
		r.len    = len;
		r.typed  = typed;
		r.exp_n  = exp_n;
		r.exp    = exp;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin : main_seq
		logic [7:0] q[$];
		int         k;
		int         phase;
		int         phase_start;

		// after reset, an end byte with no start char clears all slots
		directed_rows.push_back(mk_row(RK_BYTE, 8'h41, 1'b1, '0, '0, -1, 0, 1'b1, SLOTS,
			make_entry(3'd0, '0, '0, 1'b0, 1'b0, 1'b0)));
		// noise at both byte extremes is dropped while unaligned
		directed_rows.push_back(mk_row(RK_BYTE, 8'h00, 1'b0, '0, '0, -1, 0, 1'b0, 0, '0));
		directed_rows.push_back(mk_row(RK_BYTE, 8'hFF, 1'b0, '0, '0, -1, 0, 1'b0, 0, '0));
		// start char on the end byte itself
		directed_rows.push_back(mk_row(RK_BYTE, START_CHAR, 1'b1, '0, '0, -1, 0, 1'b1, SLOTS,
			make_entry(3'd0, '0, '0, 1'b0, 1'b0, 1'b0)));
		// address and strength extremes
		directed_rows.push_back(mk_row(RK_RECORD, START_CHAR, 1'b0, 64'h0, 8'h00, -1, 0, 1'b1,
			1, make_entry(3'd0, 64'h0, 8'h00, 1'b1, 1'b0, 1'b0)));
		directed_rows.push_back(mk_row(RK_RECORD, 8'h00, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF,
			-1, 0, 1'b1, 1, make_entry(3'd1, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1, 1'b0, 1'b0)));
		directed_rows.push_back(mk_row(RK_RECORD, 8'hFF, 1'b0, 64'h0123_4567_89AB_CDEF, 8'h5A,
			-1, 0, 1'b1, 1, make_entry(3'd2, 64'h0123_4567_89AB_CDEF, 8'h5A, 1'b1, 1'b0, 1'b0)));
		// invalid digit in the address decodes as zero and flags the record
		directed_rows.push_back(mk_row(RK_RECORD, 8'h7F, 1'b0, 64'h0, 8'h11, ADDR_LO0, 0, 1'b1,
			1, make_entry(3'd3, 64'h0, 8'h11, 1'b1, 1'b1, 1'b0)));
		// invalid low strength digit
		directed_rows.push_back(mk_row(RK_RECORD, 8'h20, 1'b0, 64'hDEAD_BEEF_0BAD_F00D, 8'h80,
			STRENGTH_LO_POS, 0, 1'b1, 1,
			make_entry(3'd4, 64'hDEAD_BEEF_0BAD_F00D, 8'h80, 1'b1, 1'b1, 1'b0)));
		// fill the rest of the table
		for (k = 5; k < SLOTS; k++)
			directed_rows.push_back(mk_row(RK_RECORD, 8'(8'h30 + k),
				1'b0, 64'h0101_0101_0101_0101 * (k + 1), 8'(k * 17),
				(k == 6) ? ADDR_LO1 + 2 : -1, 0, 1'b0, 0, '0));
		// one record too many: dropped, nothing comes out
		directed_rows.push_back(mk_row(RK_RECORD, 8'h55, 1'b0, 64'h1234_5678_9ABC_DEF0, 8'h42,
			-1, 0, 1'b1, 0, '0));
		// trailing partial record dropped on a full table with overflow:
		// a single marker beat
		directed_rows.push_back(mk_row(RK_PARTIAL, 8'h00, 1'b1, '0, '0, -1, 5, 1'b1, 1,
			make_entry(3'd0, '0, '0, 1'b0, 1'b0, 1'b1)));

		// reset once
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling
		foreach (directed_rows[i]) begin
			q.delete();
			case (directed_rows[i].kind)
				RK_BYTE: begin
					q.push_back(directed_rows[i].b);
				end
				RK_RECORD: begin
					append_record(q, directed_rows[i].b, directed_rows[i].addr,
						directed_rows[i].rssi, directed_rows[i].bad_at);
				end
				default: begin
					repeat (directed_rows[i].len) q.push_back(8'($urandom_range(0, 255)));
				end
			endcase
			send_bytes(q, directed_rows[i].eor, directed_rows[i].typed, directed_rows[i].exp_n,
				directed_rows[i].exp);
		end
		wait_drained();

		// long output hold-off while end bytes keep coming, so the job queue
		// fills and the input stalls; the record ends on its end byte, so its
		// entry comes first and the cleared slots follow
		hold_request = HOLD_CYCLES;
		send_byte(START_CHAR, 1'b1, 1'b0, 0, '0);
		send_byte(8'h00, 1'b1, 1'b0, 0, '0);
		send_byte(8'hFF, 1'b1, 1'b0, 0, '0);
		send_byte(START_CHAR, 1'b1, 1'b0, 0, '0);
		q.delete();
		append_record(q, START_CHAR, {$urandom, $urandom}, 8'($urandom_range(0, 255)), -1);
		send_bytes(q, 1'b1, 1'b0, 0, '0);
		send_byte(8'h30, 1'b1, 1'b0, 0, '0);
		wait_drained();

		// random responses under three idle mixes
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 25;
					recv_idle_pct = 69;
				end
				1: begin
					send_idle_pct = 69;
					recv_idle_pct = 25;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < 24)
				random_response();
			wait_drained();
		end

		$display("run covered %0d bytes in %0d responses, %0d entries compared",
			bytes_sent, responses_sent, entries_checked);
		$display("directed rows %0d, one long output hold-off, three idle mixes",
			directed_rows.size());
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
